/* hw/rtl/utf8dc_pkg.sv */
// ----------------------------------------------------------------------------
// utf8dc_pkg
// Shared types, constants and helpers for the UTF-8 decoder with display
// column tracking.
// ----------------------------------------------------------------------------
package utf8dc_pkg;

    localparam int LINE_BYTES  = 4096;
    localparam int POS_W       = $clog2(LINE_BYTES);
    localparam int CP_W        = 21;
    localparam int COL_W       = 13;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [POS_W-1:0] POS_MAX   = POS_W'(LINE_BYTES - 1);
    localparam logic [COL_W-1:0] COL_MAX   = {COL_W{1'b1}};
    localparam logic [CP_W-1:0]  REPL_CHAR = 21'h00FFFD;

    typedef enum logic [2:0] {
        LEAD_ASCII,
        LEAD_TWO,
        LEAD_THREE,
        LEAD_FOUR,
        LEAD_BAD
    } lead_kind_t;

    // One accepted byte, as a run of results for the back end
    typedef struct packed {
        logic [1:0]       pre_cnt;
        logic [POS_W-1:0] pre_start;
        logic             has_char;
        logic [CP_W-1:0]  char_cp;
        logic [1:0]       char_w;
        logic [POS_W-1:0] char_off;
        logic [1:0]       post_cnt;
        logic [POS_W-1:0] post_start;
        logic [2:0]       total;
        logic             last;
    } utf8dc_cmd_t;

    function automatic logic [1:0] wide_of(input logic [CP_W-1:0] cp);
        logic wide;
        wide = (cp >= 21'h04E00 && cp <= 21'h09FFF)
            || (cp >= 21'h03400 && cp <= 21'h04DBF)
            || (cp >= 21'h20000 && cp <= 21'h2A6DF)
            || (cp >= 21'h0F900 && cp <= 21'h0FAFF)
            || (cp >= 21'h0AC00 && cp <= 21'h0D7AF)
            || (cp >= 21'h01100 && cp <= 21'h011FF)
            || (cp >= 21'h03040 && cp <= 21'h030FF)
            || (cp >= 21'h03000 && cp <= 21'h0303F)
            || (cp >= 21'h0FF01 && cp <= 21'h0FF60)
            || (cp >= 21'h0FFE0 && cp <= 21'h0FFE6)
            || (cp >= 21'h03200 && cp <= 21'h033FF)
            || (cp >= 21'h02E80 && cp <= 21'h02FFF)
            || (cp >= 21'h03100 && cp <= 21'h0312F);
        return wide ? 2'd2 : 2'd1;
    endfunction

    function automatic logic [POS_W-1:0] pos_add(input logic [POS_W-1:0] a,
                                                 input logic [1:0]       k);
        logic [POS_W:0] sum;
        sum = {1'b0, a} + {{(POS_W-1){1'b0}}, k};
        return (sum > {1'b0, POS_MAX}) ? POS_MAX : sum[POS_W-1:0];
    endfunction

endpackage

/* hw/rtl/utf8dc_front.sv */
// ----------------------------------------------------------------------------
// utf8dc_front
// Accepts bytes, tracks the pending UTF-8 sequence and turns each byte into
// a command that lists the results it causes.
// ----------------------------------------------------------------------------
module utf8dc_front
    import utf8dc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    output logic             byte_stall,
    input  logic [7:0]       in_byte,
    input  logic             line_end,
    input  logic             queue_full,
    output logic             cmd_valid,
    output utf8dc_cmd_t      cmd
);

    logic [CP_W-1:0]  pp_reg, pp_next;
    logic [1:0]       bexp_reg, bexp_next;
    logic [1:0]       btaken_reg, btaken_next;
    logic [POS_W-1:0] seqst_reg, seqst_next;
    logic [POS_W-1:0] bpos_reg, bpos_next;

    logic             accept;
    logic             pending;
    logic             is_cont;
    logic [CP_W-1:0]  cont_pp;
    lead_kind_t       kind;
    utf8dc_cmd_t      c;

    assign byte_stall = queue_full;
    assign accept     = byte_valid && !queue_full;
    assign cmd_valid  = accept && (c.total != 3'd0);
    assign cmd        = c;

    always_comb
    begin
        if (in_byte[7] == 1'b0)
            kind = LEAD_ASCII;
        else if (in_byte[7:5] == 3'b110)
            kind = LEAD_TWO;
        else if (in_byte[7:4] == 4'b1110)
            kind = LEAD_THREE;
        else if (in_byte[7:3] == 5'b11110)
            kind = LEAD_FOUR;
        else
            kind = LEAD_BAD;
    end

    always_comb
    begin
        pending     = (bexp_reg != 2'd0);
        is_cont     = (in_byte[7:6] == 2'b10);
        cont_pp     = {pp_reg[CP_W-7:0], in_byte[5:0]};
        pp_next     = pp_reg;
        bexp_next   = bexp_reg;
        btaken_next = btaken_reg;
        seqst_next  = seqst_reg;
        c           = '0;

        if (pending && is_cont)
        begin
            if (bexp_reg == 2'd1)
            begin
                c.has_char  = 1'b1;
                c.char_cp   = cont_pp;
                c.char_off  = seqst_reg;
                pp_next     = '0;
                bexp_next   = 2'd0;
                btaken_next = 2'd0;
            end
            else
            begin
                pp_next     = cont_pp;
                bexp_next   = bexp_reg - 2'd1;
                btaken_next = btaken_reg + 2'd1;
            end
        end
        else
        begin
            if (pending)
            begin
                c.pre_cnt   = btaken_reg;
                c.pre_start = seqst_reg;
            end
            pp_next     = '0;
            bexp_next   = 2'd0;
            btaken_next = 2'd0;
            unique case (kind)
                LEAD_ASCII:
                begin
                    c.has_char = 1'b1;
                    c.char_cp  = {13'd0, in_byte};
                    c.char_off = bpos_reg;
                end
                LEAD_TWO:
                begin
                    pp_next     = {16'd0, in_byte[4:0]};
                    bexp_next   = 2'd1;
                    btaken_next = 2'd1;
                    seqst_next  = bpos_reg;
                end
                LEAD_THREE:
                begin
                    pp_next     = {17'd0, in_byte[3:0]};
                    bexp_next   = 2'd2;
                    btaken_next = 2'd1;
                    seqst_next  = bpos_reg;
                end
                LEAD_FOUR:
                begin
                    pp_next     = {18'd0, in_byte[2:0]};
                    bexp_next   = 2'd3;
                    btaken_next = 2'd1;
                    seqst_next  = bpos_reg;
                end
                default:
                begin
                    c.has_char = 1'b1;
                    c.char_cp  = REPL_CHAR;
                    c.char_off = bpos_reg;
                end
            endcase
        end

        c.char_w  = wide_of(c.char_cp);
        bpos_next = pos_add(bpos_reg, 2'd1);

        if (line_end)
        begin
            c.post_cnt   = btaken_next;
            c.post_start = seqst_next;
            c.last       = 1'b1;
            pp_next      = '0;
            bexp_next    = 2'd0;
            btaken_next  = 2'd0;
            seqst_next   = '0;
            bpos_next    = '0;
        end

        c.total = {1'b0, c.pre_cnt} + {2'd0, c.has_char} + {1'b0, c.post_cnt};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_reg     <= '0;
            bexp_reg   <= 2'd0;
            btaken_reg <= 2'd0;
            seqst_reg  <= '0;
            bpos_reg   <= '0;
        end
        else if (accept)
        begin
            pp_reg     <= pp_next;
            bexp_reg   <= bexp_next;
            btaken_reg <= btaken_next;
            seqst_reg  <= seqst_next;
            bpos_reg   <= bpos_next;
        end
    end

endmodule

/* hw/rtl/utf8dc_queue.sv */
// ----------------------------------------------------------------------------
// utf8dc_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module utf8dc_queue
    import utf8dc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  utf8dc_cmd_t push_cmd,
    input  logic        pop,
    output utf8dc_cmd_t head,
    output logic        head_valid,
    output logic        full
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    utf8dc_cmd_t      slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head       = slot_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

/* hw/rtl/utf8dc_back.sv */
// ----------------------------------------------------------------------------
// utf8dc_back
// Expands each command into result items, one per cycle while char_stall
// allows, and tracks the display column.
// ----------------------------------------------------------------------------
module utf8dc_back
    import utf8dc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  utf8dc_cmd_t       head,
    input  logic              head_valid,
    output logic              pop,
    output logic              char_valid,
    input  logic              char_stall,
    output logic [CP_W-1:0]   code_point,
    output logic [1:0]        char_width,
    output logic [POS_W-1:0]  char_offset,
    output logic [COL_W-1:0]  start_column,
    output logic              run_last,
    output logic              line_done
);

    logic [1:0]       idx_reg, idx_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             out_valid_reg, out_valid_next;
    logic [CP_W-1:0]  cp_reg;
    logic [1:0]       w_reg;
    logic [POS_W-1:0] off_reg;
    logic [COL_W-1:0] scol_reg;
    logic             run_last_reg;
    logic             line_done_reg;

    logic             advance;
    logic             is_final;
    logic [CP_W-1:0]  sel_cp;
    logic [1:0]       sel_w;
    logic [POS_W-1:0] sel_off;
    logic [1:0]       post_k;
    logic [COL_W:0]   col_sum;

    assign advance = head_valid && (!out_valid_reg || !char_stall);
    assign pop     = advance && is_final;

    always_comb
    begin
        is_final = ({1'b0, idx_reg} + 3'd1) == head.total;
        post_k   = idx_reg - head.pre_cnt - {1'b0, head.has_char};
        if (idx_reg < head.pre_cnt)
        begin
            sel_cp  = REPL_CHAR;
            sel_w   = 2'd1;
            sel_off = pos_add(head.pre_start, idx_reg);
        end
        else if (head.has_char && idx_reg == head.pre_cnt)
        begin
            sel_cp  = head.char_cp;
            sel_w   = head.char_w;
            sel_off = head.char_off;
        end
        else
        begin
            sel_cp  = REPL_CHAR;
            sel_w   = 2'd1;
            sel_off = pos_add(head.post_start, post_k);
        end

        col_sum        = {1'b0, col_reg} + {{(COL_W-1){1'b0}}, sel_w};
        idx_next       = idx_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (is_final)
            begin
                idx_next = 2'd0;
                col_next = head.last ? '0 :
                           (col_sum[COL_W] ? COL_MAX : col_sum[COL_W-1:0]);
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
                col_next = col_sum[COL_W] ? COL_MAX : col_sum[COL_W-1:0];
            end
        end
        else if (!char_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cp_reg        <= sel_cp;
            w_reg         <= sel_w;
            off_reg       <= sel_off;
            scol_reg      <= col_reg;
            run_last_reg  <= is_final;
            line_done_reg <= is_final && head.last;
        end
    end

    assign char_valid   = out_valid_reg;
    assign code_point   = cp_reg;
    assign char_width   = w_reg;
    assign char_offset  = off_reg;
    assign start_column = scol_reg;
    assign run_last     = run_last_reg;
    assign line_done    = line_done_reg;

endmodule

/* hw/rtl/utf8_decode_display_column_top.sv */
// ----------------------------------------------------------------------------
// utf8_decode_display_column_top
// UTF-8 decoder reporting code point, display width, byte offset and start
// column of each character of a line.
// ----------------------------------------------------------------------------
// Path: a byte's command is registered in the command queue and each of its
//   results in the back end output register; further results of the same
//   byte follow one per cycle while char_stall is low.
// Throughput: one byte per cycle while each byte gives at most one result and
//   char_stall is low; the two-entry command queue absorbs multi-result bytes.
// Reset: rst_n clears decode state, column, queue and output valid at once.
// ----------------------------------------------------------------------------
module utf8_decode_display_column_top
    import utf8dc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  logic [7:0]        in_byte,
    input  logic              line_end,
    output logic              char_valid,
    input  logic              char_stall,
    output logic [CP_W-1:0]   code_point,
    output logic [1:0]        char_width,
    output logic [POS_W-1:0]  char_offset,
    output logic [COL_W-1:0]  start_column,
    output logic              run_last,
    output logic              line_done
);

    utf8dc_cmd_t front_cmd;
    utf8dc_cmd_t head_cmd;
    logic        front_valid;
    logic        queue_full;
    logic        head_valid;
    logic        pop;

    utf8dc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .in_byte    (in_byte),
        .line_end   (line_end),
        .queue_full (queue_full),
        .cmd_valid  (front_valid),
        .cmd        (front_cmd)
    );

    utf8dc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_valid),
        .push_cmd   (front_cmd),
        .pop        (pop),
        .head       (head_cmd),
        .head_valid (head_valid),
        .full       (queue_full)
    );

    utf8dc_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_cmd),
        .head_valid   (head_valid),
        .pop          (pop),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .code_point   (code_point),
        .char_width   (char_width),
        .char_offset  (char_offset),
        .start_column (start_column),
        .run_last     (run_last),
        .line_done    (line_done)
    );

endmodule

/* tb/sv/utf8_decode_display_column_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_decode_display_column_top_tb
// Drives byte items into the UTF-8 decoder through a short table of fixed
// cases, one line of wide characters with stray bytes and a random mix of
// good, broken and noise sequences. Every result item is checked field by
// field against the bench's decoder model or, for typed table rows, the stored
// results, with random idle cycles on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module utf8_decode_display_column_top_tb;

    import utf8dc_pkg::*;

    localparam int DIR_ROWS     = 28;
    localparam int RAND_BYTES   = 176;
    localparam int LONG_CHARS   = 40;
    localparam int HOLD_AT      = 80;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_CYCLES = 1500000;

    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic [1:0]       w;
        logic [POS_W-1:0] off;
        logic [COL_W-1:0] col;
        logic             rl;
        logic             ld;
    } char_rec_t;

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
        logic       typed;
        char_rec_t  res;
    } byte_item_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             byte_valid;
    logic             byte_stall;
    logic [7:0]       in_byte;
    logic             line_end;
    logic             char_valid;
    logic             char_stall;
    logic [CP_W-1:0]  code_point;
    logic [1:0]       char_width;
    logic [POS_W-1:0] char_offset;
    logic [COL_W-1:0] start_column;
    logic             run_last;
    logic             line_done;

    logic             item_typed;
    char_rec_t        item_res;

    byte_item_t       directed_rows [DIR_ROWS];
    byte_item_t       byte_items [$];
    char_rec_t        pending_chars [$];
    char_rec_t        step_chars [$];

    logic [CP_W-1:0]  dec_partial;
    logic [1:0]       dec_need;
    logic [1:0]       dec_taken;
    logic [COL_W-1:0] dec_column;
    logic [POS_W-1:0] dec_pos;
    logic [POS_W-1:0] dec_seq_off;

    int               err_count = 0;
    int               char_count = 0;
    int               cycle_count = 0;
    bit               drive_done = 1'b0;

    utf8_decode_display_column_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .in_byte      (in_byte),
        .line_end     (line_end),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .code_point   (code_point),
        .char_width   (char_width),
        .char_offset  (char_offset),
        .start_column (start_column),
        .run_last     (run_last),
        .line_done    (line_done)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [CP_W-1:0] wide_lo(input int idx);
        case (idx)
            0:       return 21'h04E00;
            1:       return 21'h03400;
            2:       return 21'h20000;
            3:       return 21'h0F900;
            4:       return 21'h0AC00;
            5:       return 21'h01100;
            6:       return 21'h03040;
            7:       return 21'h03000;
            8:       return 21'h0FF01;
            9:       return 21'h0FFE0;
            10:      return 21'h03200;
            11:      return 21'h02E80;
            default: return 21'h03100;
        endcase
    endfunction

    function automatic logic [CP_W-1:0] wide_hi(input int idx);
        case (idx)
            0:       return 21'h09FFF;
            1:       return 21'h04DBF;
            2:       return 21'h2A6DF;
            3:       return 21'h0FAFF;
            4:       return 21'h0D7AF;
            5:       return 21'h011FF;
            6:       return 21'h030FF;
            7:       return 21'h0303F;
            8:       return 21'h0FF60;
            9:       return 21'h0FFE6;
            10:      return 21'h033FF;
            11:      return 21'h02FFF;
            default: return 21'h0312F;
        endcase
    endfunction

    function automatic logic [1:0] columns_of(input logic [CP_W-1:0] cp);
        for (int i = 0; i < 13; i++)
        begin
            if (cp >= wide_lo(i) && cp <= wide_hi(i))
                return 2'd2;
        end
        return 2'd1;
    endfunction

    function automatic logic [POS_W-1:0] sat_offset(input logic [POS_W-1:0] a,
                                                    input int unsigned    k);
        int unsigned sum;
        sum = a + k;
        return (sum > LINE_BYTES - 1) ? POS_W'(LINE_BYTES - 1) : POS_W'(sum);
    endfunction

    task automatic emit_char(input logic [CP_W-1:0] cp, input logic [POS_W-1:0] off);
        char_rec_t    r;
        int unsigned  next_col;
        r.cp  = cp;
        r.w   = columns_of(cp);
        r.off = off;
        r.col = dec_column;
        r.rl  = 1'b0;
        r.ld  = 1'b0;
        step_chars.push_back(r);
        next_col   = dec_column + r.w;
        dec_column = (next_col > 8191) ? COL_W'(8191) : COL_W'(next_col);
    endtask

    task automatic flush_sequence();
        for (int k = 0; k < dec_taken; k++)
            emit_char(REPL_CHAR, sat_offset(dec_seq_off, k));
        dec_need    = 2'd0;
        dec_taken   = 2'd0;
        dec_partial = '0;
    endtask

    task automatic start_sequence(input logic [7:0] b, input logic [POS_W-1:0] off);
        if (b[7] == 1'b0)
        begin
            emit_char({13'd0, b}, off);
            return;
        end
        if (b[7:5] == 3'b110)
        begin
            dec_partial = {16'd0, b[4:0]};
            dec_need    = 2'd1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            dec_partial = {17'd0, b[3:0]};
            dec_need    = 2'd2;
        end
        else if (b[7:3] == 5'b11110)
        begin
            dec_partial = {18'd0, b[2:0]};
            dec_need    = 2'd3;
        end
        else
        begin
            emit_char(REPL_CHAR, off);
            return;
        end
        dec_taken   = 2'd1;
        dec_seq_off = off;
    endtask

    task automatic clear_decoder();
        dec_partial = '0;
        dec_need    = 2'd0;
        dec_taken   = 2'd0;
        dec_column  = '0;
        dec_pos     = '0;
        dec_seq_off = '0;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic fin);
        logic [POS_W-1:0] off;
        off = dec_pos;
        step_chars.delete();
        if (dec_need != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                dec_partial = {dec_partial[CP_W-7:0], b[5:0]};
                dec_need    = dec_need - 2'd1;
                dec_taken   = dec_taken + 2'd1;
                if (dec_need == 2'd0)
                begin
                    emit_char(dec_partial, dec_seq_off);
                    dec_taken   = 2'd0;
                    dec_partial = '0;
                end
            end
            else
            begin
                flush_sequence();
                start_sequence(b, off);
            end
        end
        else
        begin
            start_sequence(b, off);
        end
        dec_pos = sat_offset(dec_pos, 1);
        if (fin)
        begin
            flush_sequence();
            clear_decoder();
        end
        if (step_chars.size() > 0)
        begin
            step_chars[step_chars.size() - 1].rl = 1'b1;
            step_chars[step_chars.size() - 1].ld = fin;
        end
    endtask

    task automatic check_field(input string name, input logic [CP_W-1:0] want,
                               input logic [CP_W-1:0] seen);
        if (want !== seen)
        begin
            err_count++;
            if (err_count <= 40)
                $display("%0t: %s expected %0h, actual %0h", $time, name, want, seen);
        end
    endtask

    always @(posedge clk)
    begin
        char_rec_t want;
        if (rst_n && byte_valid && !byte_stall)
        begin
            decode_byte(in_byte, line_end);
            if (item_typed)
                pending_chars.push_back(item_res);
            else
                foreach (step_chars[i])
                    pending_chars.push_back(step_chars[i]);
        end
        if (rst_n && char_valid && !char_stall)
        begin
            char_count++;
            if (pending_chars.size() == 0)
            begin
                err_count++;
                if (err_count <= 40)
                    $display("%0t: no item expected, actual code_point %0h", $time,
                             code_point);
            end
            else
            begin
                want = pending_chars.pop_front();
                check_field("code_point", want.cp, code_point);
                check_field("char_width", {19'd0, want.w}, {19'd0, char_width});
                check_field("char_offset", {9'd0, want.off}, {9'd0, char_offset});
                check_field("start_column", {8'd0, want.col}, {8'd0, start_column});
                check_field("run_last", {20'd0, want.rl}, {20'd0, run_last});
                check_field("line_done", {20'd0, want.ld}, {20'd0, line_done});
            end
        end
    end

    function automatic logic [7:0] enc_byte(input logic [CP_W-1:0] cp, input int n,
                                            input int i);
        logic [CP_W-1:0] bits;
        bits = cp >> (6 * (n - 1 - i));
        if (i != 0)
            return {2'b10, bits[5:0]};
        case (n)
            1:       return {1'b0, bits[6:0]};
            2:       return {3'b110, bits[4:0]};
            3:       return {4'b1110, bits[3:0]};
            default: return {5'b11110, bits[2:0]};
        endcase
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic fin);
        byte_item_t it;
        it       = '0;
        it.b     = b;
        it.fin   = fin;
        byte_items.push_back(it);
    endtask

    task automatic add_char(input logic [CP_W-1:0] cp, input int n);
        for (int i = 0; i < n; i++)
            add_byte(enc_byte(cp, n, i), 1'b0);
    endtask

    function automatic logic [CP_W-1:0] pick_wide_cp();
        int              idx;
        logic [CP_W-1:0] lo;
        logic [CP_W-1:0] hi;
        idx = $urandom_range(0, 12);
        lo  = wide_lo(idx);
        hi  = wide_hi(idx);
        case ($urandom_range(0, 4))
            0:       return lo;
            1:       return hi;
            2:       return lo - 21'd1;
            3:       return hi + 21'd1;
            default: return lo + CP_W'($urandom_range(0, hi - lo));
        endcase
    endfunction

    task automatic build_random();
        int              start_size;
        int              kind;
        int              n;
        int              k;
        logic [CP_W-1:0] cp;
        logic [7:0]      bad;
        start_size = byte_items.size();
        while (byte_items.size() - start_size < RAND_BYTES)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 25)
            begin
                add_char(CP_W'($urandom_range(0, 127)), 1);
            end
            else if (kind < 40)
            begin
                add_char(CP_W'($urandom_range(0, 2047)), 2);
            end
            else if (kind < 60)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    cp = pick_wide_cp();
                    add_char(cp, (cp > 21'h0FFFF) ? 4 : 3);
                end
                else
                begin
                    add_char(CP_W'($urandom_range(0, 16'hFFFF)), 3);
                end
            end
            else if (kind < 72)
            begin
                add_char(CP_W'($urandom_range(0, 21'h1FFFFF)), 4);
            end
            else if (kind < 85)
            begin
                n  = $urandom_range(2, 4);
                k  = $urandom_range(0, n - 2);
                cp = CP_W'($urandom_range(0, 21'h1FFFFF));
                for (int i = 0; i <= k; i++)
                    add_byte(enc_byte(cp, n, i), 1'b0);
                if ($urandom_range(0, 2) == 0)
                begin
                    byte_items[byte_items.size() - 1].fin = 1'b1;
                end
                else
                begin
                    bad = 8'($urandom_range(0, 255));
                    if (bad[7:6] == 2'b10)
                        bad[6] = 1'b1;
                    add_byte(bad, 1'b0);
                end
            end
            else
            begin
                add_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            if ($urandom_range(0, 9) == 0)
                byte_items[byte_items.size() - 1].fin = 1'b1;
        end
        byte_items[byte_items.size() - 1].fin = 1'b1;
    endtask

    // sender
    initial
    begin
        int  gap;
        bit  burst;
        byte_valid = 1'b0;
        in_byte    = 8'h00;
        line_end   = 1'b0;
        item_typed = 1'b0;
        item_res   = '0;
        burst      = 1'b0;

        directed_rows = '{
            '{8'h00, 1'b0, 1'b1, '{21'h000000, 2'd1, 12'd0, 13'd0, 1'b1, 1'b0}},
            '{8'h7F, 1'b0, 1'b1, '{21'h00007F, 2'd1, 12'd1, 13'd1, 1'b1, 1'b0}},
            '{8'hFF, 1'b0, 1'b1, '{21'h00FFFD, 2'd1, 12'd2, 13'd2, 1'b1, 1'b0}},
            '{8'h80, 1'b0, 1'b1, '{21'h00FFFD, 2'd1, 12'd3, 13'd3, 1'b1, 1'b0}},
            '{8'h41, 1'b1, 1'b1, '{21'h000041, 2'd1, 12'd4, 13'd4, 1'b1, 1'b1}},
            '{8'hF8, 1'b1, 1'b1, '{21'h00FFFD, 2'd1, 12'd0, 13'd0, 1'b1, 1'b1}},
            '{8'hC3, 1'b0, 1'b0, '0},
            '{8'hA9, 1'b0, 1'b0, '0},
            '{8'hE4, 1'b0, 1'b0, '0},
            '{8'hB8, 1'b0, 1'b0, '0},
            '{8'h80, 1'b0, 1'b0, '0},
            '{8'hF0, 1'b0, 1'b0, '0},
            '{8'hA0, 1'b0, 1'b0, '0},
            '{8'h80, 1'b0, 1'b0, '0},
            '{8'h80, 1'b0, 1'b0, '0},
            '{8'hF7, 1'b0, 1'b0, '0},
            '{8'hBF, 1'b0, 1'b0, '0},
            '{8'hBF, 1'b0, 1'b0, '0},
            '{8'hBF, 1'b0, 1'b0, '0},
            '{8'hE4, 1'b0, 1'b0, '0},
            '{8'h41, 1'b0, 1'b0, '0},
            '{8'hF0, 1'b0, 1'b0, '0},
            '{8'h90, 1'b0, 1'b0, '0},
            '{8'h8F, 1'b0, 1'b0, '0},
            '{8'hF8, 1'b0, 1'b0, '0},
            '{8'hF0, 1'b0, 1'b0, '0},
            '{8'h90, 1'b0, 1'b0, '0},
            '{8'h8F, 1'b1, 1'b0, '0}
        };
        for (int i = 0; i < DIR_ROWS; i++)
            byte_items.push_back(directed_rows[i]);

        // line of wide characters with stray bytes
        for (int i = 0; i < LONG_CHARS; i++)
        begin
            if (i % 13 == 12)
                add_byte(8'hFF, 1'b0);
            else
                add_char(21'h04E00 + CP_W'($urandom_range(0, 21'h051FF)), 3);
        end
        add_byte(8'hF0, 1'b0);
        add_byte(8'h90, 1'b1);

        build_random();

        wait (rst_n === 1'b1);
        @(posedge clk);
        foreach (byte_items[i])
        begin
            if ($urandom_range(0, 31) == 0)
                burst = !burst;
            gap = burst ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            byte_valid <= 1'b1;
            in_byte    <= byte_items[i].b;
            line_end   <= byte_items[i].fin;
            item_typed <= byte_items[i].typed;
            item_res   <= byte_items[i].res;
            @(posedge clk);
            while (byte_stall)
                @(posedge clk);
        end
        byte_valid <= 1'b0;
        drive_done = 1'b1;
    end

    // receiver
    initial
    begin
        int  wait_cycles;
        bit  burst;
        bit  held;
        char_stall = 1'b0;
        burst      = 1'b0;
        held       = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                burst = !burst;
            wait_cycles = burst ? 0 : $urandom_range(0, 3);
            if (!held && char_count >= HOLD_AT)
            begin
                held        = 1'b1;
                wait_cycles = LONG_HOLD;
            end
            if (wait_cycles > 0)
            begin
                char_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            char_stall <= 1'b0;
            @(posedge clk);
            while (!char_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait (drive_done);
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && pending_chars.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/utf8dc_pkg.sv
hw/rtl/utf8dc_front.sv
hw/rtl/utf8dc_queue.sv
hw/rtl/utf8dc_back.sv
hw/rtl/utf8_decode_display_column_top.sv
tb/sv/utf8_decode_display_column_top_tb.sv
